@@ design/tmmn_pkg.sv @@
// Shared constants, widths and divider interface types for the trimmed mean normaliser.
`timescale 1ns / 1ps
`default_nettype none
package tmmn_pkg;

	localparam int CHANNELS   = 7;
	localparam int MAX_WINDOW = 64;

	// Fixed field widths
	localparam int CH_W      = 3;
	localparam int SAMPLE_W  = 8;
	localparam int CFG_W     = 7;
	localparam int NORM_W    = 7;
	localparam int CENTER_W  = 8;
	localparam int OUT_SUM_W = 11;

	localparam int SAMPLE_MAX    = 255;
	localparam int RESET_WINDOW  = 22;
	localparam int MIN_WINDOW    = 3;
	localparam int NORM_SCALE    = 100;
	localparam int CENTER_OFFSET = 128;

	// Derived widths
	localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
	localparam int EFF_W      = (CNT_W > CFG_W) ? CNT_W : CFG_W;
	localparam int SUM_W      = $clog2(MAX_WINDOW * SAMPLE_MAX + 1);
	localparam int NORM_NUM_W = $clog2(NORM_SCALE * SAMPLE_MAX + 1);
	localparam int DIV_W      = (SUM_W > NORM_NUM_W) ? SUM_W : NORM_NUM_W;
	localparam int DVS_W      = SAMPLE_W;
	localparam int STEP_W     = (DIV_W > 1) ? $clog2(DIV_W) : 1;
	localparam int IDX_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int TOT_W      = $clog2(CHANNELS * SAMPLE_MAX + 1);
	localparam int CHK_W      = CH_W + 2;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [DVS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quotient;
	} div_rsp_t;

endpackage
`default_nettype wire

@@ design/tmmn_div.sv @@
// Bit-serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module tmmn_div (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire tmmn_pkg::div_req_t req,
	output      tmmn_pkg::div_rsp_t rsp
);

	logic [tmmn_pkg::DIV_W-1:0]  num_q;   // dividend shifts out, quotient shifts in
	logic [tmmn_pkg::DVS_W-1:0]  rem_q;
	logic [tmmn_pkg::DVS_W-1:0]  dvs_q;
	logic [tmmn_pkg::STEP_W-1:0] step_q;
	logic                        busy_q;
	logic                        done_q;

	logic [tmmn_pkg::DVS_W:0]   trial;
	logic [tmmn_pkg::DVS_W:0]   diff;
	logic                       qbit;
	logic [tmmn_pkg::DVS_W-1:0] rem_n;

	always_comb begin
		trial = {rem_q, num_q[tmmn_pkg::DIV_W-1]};
		diff  = trial - {1'b0, dvs_q};
		qbit  = (trial >= {1'b0, dvs_q});
		rem_n = qbit ? diff[tmmn_pkg::DVS_W-1:0] : trial[tmmn_pkg::DVS_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= tmmn_pkg::STEP_W'(tmmn_pkg::DIV_W - 1);
			end else if (busy_q) begin
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.dividend;
			dvs_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[tmmn_pkg::DIV_W-2:0], qbit};
			rem_q <= rem_n;
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = num_q;

endmodule
`default_nettype wire

@@ design/trimmed_mean_minmax_normalizer_unit.sv @@
// Top level: windowed trimmed mean per sensor channel with min/max normalisation.
`timescale 1ns / 1ps
`default_nettype none
// Samples arrive as beats on the item channel; each beat with a valid channel index adds to
// the running window (sum, minimum, maximum, count). The beat that fills the window
// (window_count samples, held to 3..MAX_WINDOW) starts the end-of-window work: the trimmed
// mean (sum less minimum and maximum, over count less two) and then the scaled value
// 100*(v-floor)/(peak-floor) are each worked out by one shared bit-serial divider at one
// quotient bit per cycle, so a completing beat keeps item_stall high through both divisions
// and any time the result register waits on result_stall. Per-channel peak, floor and latest
// value sit in flip-flops reset to 0 (floor to 255); the sum over channels is kept as a running
// total. Beats whose channel index is out of range are taken and dropped. A flat range (peak
// equal to floor) gives 0. window_count is written through cfg_write_en/cfg_write_data; the
// user must write it only while the block is idle, as the block itself does not enforce this.
module trimmed_mean_minmax_normalizer_unit (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_write_en,
	input  wire logic [tmmn_pkg::CFG_W-1:0]            cfg_write_data,
	input  wire logic                                  item_valid,
	output      logic                                  item_stall,
	input  wire logic [tmmn_pkg::CH_W-1:0]             channel,
	input  wire logic [tmmn_pkg::SAMPLE_W-1:0]         sample,
	output      logic                                  result_valid,
	input  wire logic                                  result_stall,
	output      logic [tmmn_pkg::CH_W-1:0]             out_channel,
	output      logic [tmmn_pkg::SAMPLE_W-1:0]         filtered,
	output      logic [tmmn_pkg::NORM_W-1:0]           normalized_value,
	output      logic signed [tmmn_pkg::CENTER_W-1:0]  centered_value,
	output      logic [tmmn_pkg::OUT_SUM_W-1:0]        strength_sum
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,   // gathering samples
		ST_MEAN = 4'b0010,   // divider on the trimmed mean
		ST_NORM = 4'b0100,   // divider on the scaled value
		ST_EMIT = 4'b1000    // waiting for the result register
	} state_t;

	state_t state_q;

	logic [tmmn_pkg::CFG_W-1:0]    window_count_q;
	logic [tmmn_pkg::CNT_W-1:0]    cnt_q;
	logic [tmmn_pkg::SUM_W-1:0]    sum_q;
	logic [tmmn_pkg::SAMPLE_W-1:0] low_q;
	logic [tmmn_pkg::SAMPLE_W-1:0] high_q;

	logic [tmmn_pkg::SAMPLE_W-1:0] peak_q   [tmmn_pkg::CHANNELS];
	logic [tmmn_pkg::SAMPLE_W-1:0] floor_q  [tmmn_pkg::CHANNELS];
	logic [tmmn_pkg::SAMPLE_W-1:0] latest_q [tmmn_pkg::CHANNELS];
	logic [tmmn_pkg::TOT_W-1:0]    total_q;

	// End-of-window working registers
	logic [tmmn_pkg::CH_W-1:0]     ch_q;
	logic [tmmn_pkg::SAMPLE_W-1:0] filt_q;
	logic                          flat_q;
	logic [tmmn_pkg::NORM_W-1:0]   norm_q;

	// Result register
	logic                           res_valid_q;
	logic [tmmn_pkg::CH_W-1:0]      res_ch_q;
	logic [tmmn_pkg::SAMPLE_W-1:0]  res_filt_q;
	logic [tmmn_pkg::NORM_W-1:0]    res_norm_q;
	logic [tmmn_pkg::OUT_SUM_W-1:0] res_sum_q;

	tmmn_pkg::div_req_t div_req;
	tmmn_pkg::div_rsp_t div_rsp;

	logic                          accept;
	logic                          ch_ok;
	logic [tmmn_pkg::SUM_W-1:0]    sum_n;
	logic [tmmn_pkg::SAMPLE_W-1:0] low_n;
	logic [tmmn_pkg::SAMPLE_W-1:0] high_n;
	logic [tmmn_pkg::CNT_W-1:0]    cnt_n;
	logic [tmmn_pkg::EFF_W-1:0]    wc_ext;
	logic [tmmn_pkg::EFF_W-1:0]    eff_count;
	logic                          win_full;
	logic [tmmn_pkg::SUM_W-1:0]    trimmed;

	logic [tmmn_pkg::IDX_W-1:0]      idx;
	logic [tmmn_pkg::SAMPLE_W-1:0]   filt_n;
	logic [tmmn_pkg::SAMPLE_W-1:0]   peak_n;
	logic [tmmn_pkg::SAMPLE_W-1:0]   floor_n;
	logic [tmmn_pkg::SAMPLE_W-1:0]   span;
	logic [tmmn_pkg::SAMPLE_W-1:0]   offs;
	logic [tmmn_pkg::NORM_NUM_W-1:0] scaled;
	logic                            res_free;

	assign item_stall = (state_q != ST_IDLE);
	assign accept     = item_valid && !item_stall;
	assign ch_ok      = ({2'b00, channel} < tmmn_pkg::CHK_W'(tmmn_pkg::CHANNELS));
	assign res_free   = !res_valid_q || !result_stall;

	// Window accumulation for the beat on the input
	always_comb begin
		sum_n  = sum_q + tmmn_pkg::SUM_W'(sample);
		low_n  = (sample < low_q)  ? sample : low_q;
		high_n = (sample > high_q) ? sample : high_q;
		cnt_n  = cnt_q + 1'b1;
		wc_ext = tmmn_pkg::EFF_W'(window_count_q);
		if (wc_ext < tmmn_pkg::EFF_W'(tmmn_pkg::MIN_WINDOW)) begin
			eff_count = tmmn_pkg::EFF_W'(tmmn_pkg::MIN_WINDOW);
		end else if (wc_ext > tmmn_pkg::EFF_W'(tmmn_pkg::MAX_WINDOW)) begin
			eff_count = tmmn_pkg::EFF_W'(tmmn_pkg::MAX_WINDOW);
		end else begin
			eff_count = wc_ext;
		end
		win_full = (tmmn_pkg::EFF_W'(cnt_n) >= eff_count);
		trimmed  = sum_n - tmmn_pkg::SUM_W'(low_n) - tmmn_pkg::SUM_W'(high_n);
	end

	// Channel update once the mean is out of the divider
	always_comb begin
		idx = tmmn_pkg::IDX_W'(ch_q);
		if (div_rsp.quotient > tmmn_pkg::DIV_W'(tmmn_pkg::SAMPLE_MAX)) begin
			filt_n = tmmn_pkg::SAMPLE_W'(tmmn_pkg::SAMPLE_MAX);
		end else begin
			filt_n = div_rsp.quotient[tmmn_pkg::SAMPLE_W-1:0];
		end
		peak_n  = (filt_n > peak_q[idx])  ? filt_n : peak_q[idx];
		floor_n = (filt_n < floor_q[idx]) ? filt_n : floor_q[idx];
		span    = peak_n - floor_n;
		offs    = filt_n - floor_n;
		scaled  = tmmn_pkg::NORM_NUM_W'(offs) * tmmn_pkg::NORM_NUM_W'(tmmn_pkg::NORM_SCALE);
	end

	// Divider requests: mean at the filling beat, scaled value after the mean
	always_comb begin
		div_req = '0;
		if (state_q == ST_IDLE && accept && ch_ok && win_full) begin
			div_req.start    = 1'b1;
			div_req.dividend = tmmn_pkg::DIV_W'(trimmed);
			div_req.divisor  = tmmn_pkg::DVS_W'(cnt_n - tmmn_pkg::CNT_W'(2));
		end else if (state_q == ST_MEAN && div_rsp.done) begin
			div_req.start    = 1'b1;
			div_req.dividend = tmmn_pkg::DIV_W'(scaled);
			div_req.divisor  = span;
		end
	end

	tmmn_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			window_count_q <= tmmn_pkg::CFG_W'(tmmn_pkg::RESET_WINDOW);
			cnt_q          <= '0;
			sum_q          <= '0;
			low_q          <= tmmn_pkg::SAMPLE_W'(tmmn_pkg::SAMPLE_MAX);
			high_q         <= '0;
			total_q        <= '0;
			res_valid_q    <= 1'b0;
			for (int i = 0; i < tmmn_pkg::CHANNELS; i++) begin
				peak_q[i]   <= '0;
				floor_q[i]  <= tmmn_pkg::SAMPLE_W'(tmmn_pkg::SAMPLE_MAX);
				latest_q[i] <= '0;
			end
		end else begin
			if (cfg_write_en) begin
				window_count_q <= cfg_write_data;
			end
			// a new beat may load as the old one leaves
			if (state_q == ST_EMIT && res_free) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !result_stall) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && ch_ok) begin
						if (win_full) begin
							cnt_q   <= '0;
							sum_q   <= '0;
							low_q   <= tmmn_pkg::SAMPLE_W'(tmmn_pkg::SAMPLE_MAX);
							high_q  <= '0;
							state_q <= ST_MEAN;
						end else begin
							cnt_q  <= cnt_n;
							sum_q  <= sum_n;
							low_q  <= low_n;
							high_q <= high_n;
						end
					end
				end
				ST_MEAN: begin
					if (div_rsp.done) begin
						peak_q[idx]   <= peak_n;
						floor_q[idx]  <= floor_n;
						latest_q[idx] <= filt_n;
						// running total: swap this channel's old value for the new one
						total_q <= total_q + tmmn_pkg::TOT_W'(filt_n)
							- tmmn_pkg::TOT_W'(latest_q[idx]);
						state_q <= ST_NORM;
					end
				end
				ST_NORM: begin
					if (div_rsp.done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (res_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept && ch_ok && win_full) begin
			ch_q <= channel;
		end
		if (state_q == ST_MEAN && div_rsp.done) begin
			filt_q <= filt_n;
			flat_q <= !(peak_n > floor_n);
		end
		if (state_q == ST_NORM && div_rsp.done) begin
			norm_q <= flat_q ? '0 : div_rsp.quotient[tmmn_pkg::NORM_W-1:0];
		end
		if (state_q == ST_EMIT && res_free) begin
			res_ch_q   <= ch_q;
			res_filt_q <= filt_q;
			res_norm_q <= norm_q;
			res_sum_q  <= tmmn_pkg::OUT_SUM_W'(total_q);
		end
	end

	assign result_valid     = res_valid_q;
	assign out_channel      = res_ch_q;
	assign filtered         = res_filt_q;
	assign normalized_value = res_norm_q;
	assign centered_value   = $signed(tmmn_pkg::CENTER_W'(res_norm_q)
		- tmmn_pkg::CENTER_W'(tmmn_pkg::CENTER_OFFSET));
	assign strength_sum     = res_sum_q;

endmodule
`default_nettype wire

@@ design/tmmn_checker.sv @@
// Port-level checks for the trimmed mean normaliser, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module tmmn_checker (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 item_stall,
	input  wire logic                                 result_valid,
	input  wire logic                                 result_stall,
	input  wire logic [tmmn_pkg::SAMPLE_W-1:0]        filtered,
	input  wire logic [tmmn_pkg::NORM_W-1:0]          normalized_value,
	input  wire logic signed [tmmn_pkg::CENTER_W-1:0] centered_value,
	input  wire logic [tmmn_pkg::OUT_SUM_W-1:0]       strength_sum
);

	// A held result beat stays offered
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result beat dropped while stalled");

	// New results only come out of end-of-window work, which stalls the input
	a_res_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(item_stall))
		else $error("result appeared without end-of-window work");

	a_norm_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (normalized_value <= tmmn_pkg::NORM_W'(tmmn_pkg::NORM_SCALE))
			&& (centered_value < 0))
		else $error("normalised value out of range");

	// The channel sum includes this window's own value
	a_sum_covers: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (strength_sum >= tmmn_pkg::OUT_SUM_W'(filtered)))
		else $error("channel sum below filtered value");

endmodule

bind trimmed_mean_minmax_normalizer_unit tmmn_checker u_tmmn_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.item_stall       (item_stall),
	.result_valid     (result_valid),
	.result_stall     (result_stall),
	.filtered         (filtered),
	.normalized_value (normalized_value),
	.centered_value   (centered_value),
	.strength_sum     (strength_sum)
);
`default_nettype wire
